// ===== hw/rtl/es2c_pkg.sv =====
package es2c_pkg;

   // reset value of the zone offset register
   localparam logic [15:0] OFFSET_RESET = 16'd3600;

   // reciprocal multipliers, ceil(2^k / c), exact for the operand widths below
   localparam int          K675  = 36;
   localparam logic [26:0] M675  = 27'((64'd1 << K675) / 64'd675 + 64'd1);
   localparam int          K3600 = 29;
   localparam logic [17:0] M3600 = 18'((64'd1 << K3600) / 64'd3600 + 64'd1);
   localparam int          K1460 = 29;
   localparam logic [18:0] M1460 = 19'((64'd1 << K1460) / 64'd1460 + 64'd1);
   localparam int          K60   = 18;
   localparam logic [12:0] M60   = 13'((64'd1 << K60) / 64'd60 + 64'd1);
   localparam int          K365  = 27;
   localparam logic [18:0] M365  = 19'((64'd1 << K365) / 64'd365 + 64'd1);
   localparam int          K100  = 16;
   localparam logic [9:0]  M100  = 10'((64'd1 << K100) / 64'd100 + 64'd1);
   localparam int          K153  = 19;
   localparam logic [11:0] M153  = 12'((64'd1 << K153) / 64'd153 + 64'd1);
   localparam int          K5    = 14;
   localparam logic [11:0] M5    = 12'((64'd1 << K5) / 64'd5 + 64'd1);

   // days from 1600-03-01 to 1970-01-01: one 400-year era less the days from 1970-01-01 to 2000-03-01
   localparam logic [17:0] DAY_SHIFT  = 18'd135080;
   localparam logic [17:0] ERA_DAYS   = 18'd146097;
   localparam logic [11:0] ERA_BASE_0 = 12'd1600;
   localparam logic [11:0] ERA_BASE_1 = 12'd2000;
   localparam int          DEPTH      = 13;

   typedef struct packed {
      logic [32:0] sum;
      logic [25:0] q1;
      logic [6:0]  r1;
      logic [52:0] p2;
      logic [15:0] days;
      logic [16:0] sod;
      logic [17:0] doe;
      logic        era;
      logic [34:0] ph;
      logic [4:0]  hour;
      logic [11:0] remh;
      logic [36:0] t1460;
      logic [24:0] pm;
      logic [17:0] acc;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [36:0] py;
      logic [8:0]  yoe;
      logic [18:0] p100;
      logic [8:0]  doy;
      logic [22:0] pmp;
      logic [3:0]  mp;
      logic [10:0] n2;
      logic [22:0] p5;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  dom;
   } stage_type;

endpackage

// ===== hw/rtl/epoch_seconds_to_calendar.sv =====
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 UTC,
// plus the programmed zone offset (csr_wr_en / csr_wr_data, reset 3600 s),
// into a Gregorian year, month, day, hour, minute and second with full
// leap-year rules. The datapath is a 13-stage pipeline built from
// constant-reciprocal multiplies: a transfer can be taken every cycle while
// req_stall is low, and each result passes through all stage registers before
// it is presented. rsp_stall freezes the whole pipeline while the last stage
// holds a result, and req_stall follows it. Write the offset only while the
// pipeline is empty.
module epoch_seconds_to_calendar
   import es2c_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day_of_month,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second
);

   logic [15:0] offset_ff;
   logic        adv;
   logic [DEPTH:1] vld_ff, vld_in;
   stage_type   st_ff [DEPTH:1];
   stage_type   st_in [DEPTH:1];

   // pipeline moves as a whole unless the finished result is held
   assign adv       = !(vld_ff[DEPTH] && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
      end else if (csr_wr_en) begin
         offset_ff <= csr_wr_data;
      end
   end

   assign vld_in = {vld_ff[DEPTH-1:1], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
   end

   always_comb begin
      // stage 1: add zone offset, 33 bits so it never wraps
      st_in[1]     = '0;
      st_in[1].sum = 33'(req_epoch_seconds) + 33'(offset_ff);

      // stage 2: 86400 = 128 * 675, divide the upper part by 675
      st_in[2]    = st_ff[1];
      st_in[2].q1 = st_ff[1].sum[32:7];
      st_in[2].r1 = st_ff[1].sum[6:0];
      st_in[2].p2 = 53'(st_ff[1].sum[32:7]) * 53'(M675);

      // stage 3: day count and second of day
      st_in[3]      = st_ff[2];
      st_in[3].days = st_ff[2].p2[K675 +: 16];
      st_in[3].sod  = {10'(st_ff[2].q1 - 26'(st_ff[2].p2[K675 +: 16]) * 26'd675),
                       st_ff[2].r1};

      // stage 4: hour estimate; shift day count into 400-year eras
      st_in[4]    = st_ff[3];
      st_in[4].ph = 35'(st_ff[3].sod) * 35'(M3600);
      st_in[4].doe = 18'(st_ff[3].days) + DAY_SHIFT;
      st_in[4].era = 1'b0;
      if (st_in[4].doe >= ERA_DAYS) begin
         st_in[4].doe = st_in[4].doe - ERA_DAYS;
         st_in[4].era = 1'b1;
      end

      // stage 5: hour, second of hour; day of era / 1460
      st_in[5]       = st_ff[4];
      st_in[5].hour  = st_ff[4].ph[K3600 +: 5];
      st_in[5].remh  = 12'(st_ff[4].sod - 17'(st_ff[4].ph[K3600 +: 5]) * 17'd3600);
      st_in[5].t1460 = 37'(st_ff[4].doe) * 37'(M1460);

      // stage 6: minute estimate; remove leap days to get a 365-day count
      st_in[6]     = st_ff[5];
      st_in[6].pm  = 25'(st_ff[5].remh) * 25'(M60);
      st_in[6].acc = st_ff[5].doe - 18'(st_ff[5].t1460[K1460 +: 7]);
      if (st_ff[5].doe >= 18'd146096) begin
         st_in[6].acc = st_in[6].acc + 18'd4 - 18'd1;
      end else if (st_ff[5].doe >= 18'd109572) begin
         st_in[6].acc = st_in[6].acc + 18'd3;
      end else if (st_ff[5].doe >= 18'd73048) begin
         st_in[6].acc = st_in[6].acc + 18'd2;
      end else if (st_ff[5].doe >= 18'd36524) begin
         st_in[6].acc = st_in[6].acc + 18'd1;
      end

      // stage 7: minute and second; year of era estimate
      st_in[7]        = st_ff[6];
      st_in[7].minute = st_ff[6].pm[K60 +: 6];
      st_in[7].second = 6'(st_ff[6].remh - 12'(st_ff[6].pm[K60 +: 6]) * 12'd60);
      st_in[7].py     = 37'(st_ff[6].acc) * 37'(M365);

      // stage 8: year of era, centuries
      st_in[8]      = st_ff[7];
      st_in[8].yoe  = st_ff[7].py[K365 +: 9];
      st_in[8].p100 = 19'(st_ff[7].py[K365 +: 9]) * 19'(M100);

      // stage 9: day of March-based year
      st_in[9]     = st_ff[8];
      st_in[9].doy = 9'(st_ff[8].doe - (18'(st_ff[8].yoe) * 18'd365
                     + 18'(st_ff[8].yoe[8:2]) - 18'(st_ff[8].p100[K100 +: 3])));

      // stage 10: March-based month estimate
      st_in[10]     = st_ff[9];
      st_in[10].pmp = 23'(11'(st_ff[9].doy) * 11'd5 + 11'd2) * 23'(M153);

      // stage 11: March-based month, its first day times 5
      st_in[11]    = st_ff[10];
      st_in[11].mp = st_ff[10].pmp[K153 +: 4];
      st_in[11].n2 = 11'(st_ff[10].pmp[K153 +: 4]) * 11'd153 + 11'd2;

      // stage 12: first day of month within March-based year
      st_in[12]    = st_ff[11];
      st_in[12].p5 = 23'(st_ff[11].n2) * 23'(M5);

      // stage 13: calendar fields, January and February belong to next year
      st_in[13]     = st_ff[12];
      st_in[13].dom = 5'(st_ff[12].doy - st_ff[12].p5[K5 +: 9] + 9'd1);
      if (st_ff[12].mp < 4'd10) begin
         st_in[13].month = st_ff[12].mp + 4'd3;
      end else begin
         st_in[13].month = st_ff[12].mp - 4'd9;
      end
      st_in[13].year = (st_ff[12].era ? ERA_BASE_1 : ERA_BASE_0) + 12'(st_ff[12].yoe)
                       + ((st_ff[12].mp >= 4'd10) ? 12'd1 : 12'd0);
   end

   assign rsp_valid        = vld_ff[DEPTH];
   assign rsp_year         = st_ff[DEPTH].year;
   assign rsp_month        = st_ff[DEPTH].month;
   assign rsp_day_of_month = st_ff[DEPTH].dom;
   assign rsp_hour         = st_ff[DEPTH].hour;
   assign rsp_minute       = st_ff[DEPTH].minute;
   assign rsp_second       = st_ff[DEPTH].second;

endmodule

// ===== test/tb_epoch_seconds_to_calendar.sv =====
`timescale 1ns / 1ps

module tb_epoch_seconds_to_calendar
   import es2c_pkg::*;
();

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } calendar_type;

   localparam int LATENCY     = 13;
   localparam int STALL_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_epoch_seconds = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [11:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day_of_month;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;

   // model copy of the zone offset register
   logic [15:0]  zone_offset;
   calendar_type pending_dates[$];
   int           errors = 0;
   int           dates_checked = 0;
   int           idle_cycles = 0;
   int           stall_mode = 0;

   always #2 clock = ~clock;

   epoch_seconds_to_calendar dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_epoch_seconds(req_epoch_seconds),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_year(rsp_year), .rsp_month(rsp_month),
      .rsp_day_of_month(rsp_day_of_month), .rsp_hour(rsp_hour),
      .rsp_minute(rsp_minute), .rsp_second(rsp_second)
   );

   function automatic bit leap_year(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   // walk years then months, the rest splits into day and time of day
   function automatic calendar_type seconds_to_date(logic [31:0] secs, logic [15:0] offs);
      longint unsigned rest;
      longint unsigned span;
      int unsigned     yr;
      int unsigned     mon;
      int unsigned     mdays[12];
      calendar_type    d;
      mdays = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      rest = longint'(secs) + longint'(offs);
      yr = 1970;
      mon = 0;
      forever begin
         span = 64'd86400 * (leap_year(yr) ? 366 : 365);
         if (rest < span) break;
         rest -= span;
         yr++;
      end
      while (mon < 12) begin
         span = mdays[mon] + ((mon == 1 && leap_year(yr)) ? 1 : 0);
         span *= 86400;
         if (rest < span) break;
         rest -= span;
         mon++;
      end
      if (mon > 11) mon = 11;
      d.year         = 12'(yr);
      d.month        = 4'(mon + 1);
      d.day_of_month = 5'(rest / 86400 + 1);
      rest %= 86400;
      d.hour         = 5'(rest / 3600);
      rest %= 3600;
      d.minute       = 6'(rest / 60);
      d.second       = 6'(rest % 60);
      return d;
   endfunction

   // receiver stall pattern: off, sparse, heavy, or random toggling
   always @(negedge clock) begin
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 9) == 0);
         2: rsp_stall <= ($urandom_range(0, 2) != 0);
         default: rsp_stall <= ($urandom_range(0, 15) < 4) ^ rsp_stall;
      endcase
      if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 3);
   end

   // result checker, sampled on the rising edge
   always @(posedge clock) begin
      calendar_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_year, rsp_month, rsp_day_of_month, rsp_hour, rsp_minute, rsp_second};
         if (pending_dates.size() == 0) begin
            $display("%0t: unexpected result transfer %p", $time, got);
            errors++;
         end else begin
            want = pending_dates.pop_front();
            dates_checked++;
            if (got.year !== want.year) begin
               $display("%0t: year expected %0d actual %0d", $time, want.year, got.year);
               errors++;
            end
            if (got.month !== want.month) begin
               $display("%0t: month expected %0d actual %0d", $time, want.month, got.month);
               errors++;
            end
            if (got.day_of_month !== want.day_of_month) begin
               $display("%0t: day expected %0d actual %0d", $time, want.day_of_month,
                        got.day_of_month);
               errors++;
            end
            if (got.hour !== want.hour) begin
               $display("%0t: hour expected %0d actual %0d", $time, want.hour, got.hour);
               errors++;
            end
            if (got.minute !== want.minute) begin
               $display("%0t: minute expected %0d actual %0d", $time, want.minute,
                        got.minute);
               errors++;
            end
            if (got.second !== want.second) begin
               $display("%0t: second expected %0d actual %0d", $time, want.second,
                        got.second);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("FAIL epoch_seconds_to_calendar");
         $finish;
      end
   end

   // one request transfer; payload held until accepted
   task automatic send_epoch(logic [31:0] secs);
      req_valid <= 1'b1;
      req_epoch_seconds <= secs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_dates = {pending_dates, seconds_to_date(secs, zone_offset)};
      @(negedge clock);
   endtask

   // lower valid and wait a random gap
   task automatic pause_sender(int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // offset write only once the pipeline has drained
   task automatic write_offset(logic [15:0] value);
      req_valid <= 1'b0;
      while (pending_dates.size() != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      zone_offset = value;
   endtask

   // boundaries: zero, all ones, leap days, century years, single bits
   task automatic test_directed_edges();
      logic [31:0] picks[$];
      picks = '{32'd0, 32'hFFFF_FFFF, 32'd951782400, 32'd951868800, 32'd4107542399,
                32'd4107542400, 32'd68169599, 32'd946684799, 32'h5555_5555,
                32'hAAAA_AAAA, 32'd1709164800, 32'd4102444800};
      foreach (picks[i]) send_epoch(picks[i]);
      for (int b = 0; b < 32; b += 4) send_epoch(32'd1 << b);
   endtask

   // year rollover with large offsets, the extreme offset against max input
   task automatic test_offset_extremes();
      write_offset(16'd0);
      send_epoch(32'd0);
      send_epoch(32'd31535999);
      send_epoch(32'hFFFF_FFFF);
      write_offset(16'hFFFF);
      send_epoch(32'hFFFF_FFFF);
      send_epoch(32'd31536000 - 32'd65535);
      send_epoch(32'd0);
      write_offset(16'd50400);
      send_epoch(32'd951825600);
      send_epoch(32'hFFFF_FFFF);
   endtask

   // random bursts under several offsets, mostly full range, some near year ends
   task automatic test_random_traffic(int unsigned count);
      int unsigned left;
      int unsigned burst;
      logic [31:0] secs;
      left = count;
      while (left > 0) begin
         if (left % 400 == 0) write_offset(16'($urandom_range(0, 65535)));
         burst = $urandom_range(1, 24);
         while (burst > 0 && left > 0) begin
            case ($urandom_range(0, 3))
               0: secs = 32'((longint'($urandom_range(0, 135)) * 31556952) +
                             $urandom_range(0, 200000) - 100000);
               default: secs = $urandom;
            endcase
            send_epoch(secs);
            burst--;
            left--;
         end
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 20));
      end
   endtask

   initial begin
      zone_offset = OFFSET_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_edges();
      test_offset_extremes();
      test_random_traffic(1720);
      req_valid <= 1'b0;
      while (pending_dates.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
      $display("checked %0d calendar conversions over directed and random epochs",
               dates_checked);
      $display("offsets covered reset, zero, full 16-bit and random values");
      if (errors == 0 && pending_dates.size() == 0)
         $display("PASS epoch_seconds_to_calendar");
      else
         $display("FAIL epoch_seconds_to_calendar");
      $finish;
   end

endmodule
